// ===== rtl/rtpfu_pkg.sv =====
// ----------------------------------------------------------------------------
// rtpfu_pkg
// Shared types and constants for the H.264 RTP FU-A packetizer.
// ----------------------------------------------------------------------------
`default_nettype none
package rtpfu_pkg;
  localparam int unsigned NalLenBitsDef = 32;
  localparam logic [15:0] MaxSingleRst  = 16'd1436;
  localparam logic [15:0] FragPayRst    = 16'd1436;
  localparam logic [6:0]  PayKindRst    = 7'h61;
  localparam logic [31:0] SourceIdRst   = 32'h0000_6952;
  localparam logic [2:0]  LenBytesRst   = 3'd4;
  localparam logic [4:0]  FuAType       = 5'd28;
  localparam logic [7:0]  RtpVersion    = 8'h80;

  typedef enum logic [2:0] {
    REG_LEN_BYTES = 3'd0,
    REG_MAX_SINGLE = 3'd1,
    REG_FRAG_PAY = 3'd2,
    REG_PAY_KIND = 3'd3,
    REG_SOURCE_ID = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_PREFIX  = 2'd0,
    PH_HEAD    = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  // Command handed from front to back: one per emitting input word.
  typedef struct packed {
    logic        hdr;       // emit 12-byte RTP header first
    logic        fu;        // emit FU indicator and FU header after header
    logic        marker;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
    logic [7:0]  data;
    logic        last;      // data byte ends the packet
  } cmd_t;

  typedef struct packed {
    logic [6:0]  pay_kind;
    logic [31:0] source_id;
  } hdr_cfg_t;
endpackage
`default_nettype wire

// ===== rtl/rtpfu_front.sv =====
// ----------------------------------------------------------------------------
// rtpfu_front
// Parses length prefixes and NAL heads, decides single/FU-A, issues commands.
// ----------------------------------------------------------------------------
`default_nettype none
module rtpfu_front #(
  parameter int unsigned NAL_LEN_BITS = rtpfu_pkg::NalLenBitsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              first_of_unit_i,
  input  wire logic              in_last_nal_i,
  input  wire logic [31:0]       media_time_i,
  input  wire logic [2:0]        len_bytes_i,
  input  wire logic [15:0]       max_single_i,
  input  wire logic [15:0]       frag_pay_i,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output rtpfu_pkg::cmd_t        cmd_o
);
  rtpfu_pkg::phase_e phase_q, phase_d;
  logic [2:0]              pcnt_q, pcnt_d;
  logic [NAL_LEN_BITS-1:0] nal_q, nal_d, nal_acc, nal_dec;
  logic [15:0]             frag_q, frag_d, frag_dec, fp;
  logic [15:0]             seq_q, seq_d, seq_inc;
  logic [31:0]             time_q, time_d, ts_now;
  logic [7:0]              ind_q, ind_d;
  logic [4:0]              typ_q, typ_d;
  logic                    spend_q, spend_d, frag_on_q, frag_on_d;
  logic [2:0]              lb, pcnt_inc;
  logic                    emit, acc, is_last, single;

  assign ready_o = cmd_ready_i;
  assign acc     = valid_i && ready_o;
  assign ts_now  = first_of_unit_i ? media_time_i : time_q;
  assign seq_inc = seq_q + 16'd1;
  assign nal_dec = nal_q - NAL_LEN_BITS'(1);
  assign fp      = (frag_pay_i == 16'd0) ? 16'd1 : frag_pay_i;
  assign lb      = (len_bytes_i == 3'd0) ? 3'd1 : ((len_bytes_i > 3'd4) ? 3'd4 : len_bytes_i);
  assign nal_acc = (pcnt_q == 3'd0) ? NAL_LEN_BITS'(data_byte_i)
                                    : {nal_q[NAL_LEN_BITS-9:0], data_byte_i};
  assign pcnt_inc = pcnt_q + 3'd1;
  assign single  = (nal_q <= NAL_LEN_BITS'(max_single_i)) || (nal_q == NAL_LEN_BITS'(1));
  assign is_last = (nal_q <= NAL_LEN_BITS'(fp));
  assign frag_dec = ((frag_q == 16'd0) ? (is_last ? nal_q[15:0] : fp) : frag_q) - 16'd1;

  always_comb begin
    phase_d = phase_q; pcnt_d = pcnt_q; nal_d = nal_q; frag_d = frag_q;
    seq_d = seq_q; time_d = ts_now; ind_d = ind_q; typ_d = typ_q;
    spend_d = spend_q; frag_on_d = frag_on_q;
    emit = 1'b0;
    cmd_o = '0;
    cmd_o.ts = ts_now;
    cmd_o.data = data_byte_i;
    cmd_o.fu_ind = ind_q;
    cmd_o.seq = seq_inc;
    case (phase_q)
      rtpfu_pkg::PH_HEAD: begin
        nal_d = nal_dec;
        if (single) begin
          emit = 1'b1; frag_on_d = 1'b0; seq_d = seq_inc;
          cmd_o.hdr = 1'b1; cmd_o.marker = in_last_nal_i;
          cmd_o.last = (nal_dec == '0);
          phase_d = (nal_dec == '0) ? rtpfu_pkg::PH_PREFIX : rtpfu_pkg::PH_PAYLOAD;
        end else begin
          frag_on_d = 1'b1;
          ind_d = (data_byte_i & 8'h60) | {3'b000, rtpfu_pkg::FuAType};
          typ_d = data_byte_i[4:0];
          spend_d = 1'b1; frag_d = 16'd0;
          phase_d = rtpfu_pkg::PH_PAYLOAD;
        end
      end
      rtpfu_pkg::PH_PAYLOAD: begin
        emit = 1'b1;
        nal_d = nal_dec;
        if (frag_on_q) begin
          if (frag_q == 16'd0) begin
            seq_d = seq_inc; spend_d = 1'b0;
            cmd_o.hdr = 1'b1; cmd_o.fu = 1'b1;
            cmd_o.marker = is_last && in_last_nal_i;
            cmd_o.fu_hdr = {spend_q, is_last, 1'b0, typ_q};
          end
          frag_d = frag_dec;
          cmd_o.last = (frag_dec == 16'd0);
        end else begin
          cmd_o.last = (nal_dec == '0);
        end
        if (nal_dec == '0) begin
          phase_d = rtpfu_pkg::PH_PREFIX; frag_on_d = 1'b0; frag_d = 16'd0;
        end
      end
      default: begin
        nal_d = nal_acc;
        if (pcnt_inc >= lb) begin
          pcnt_d = 3'd0;
          phase_d = (nal_acc == '0) ? rtpfu_pkg::PH_PREFIX : rtpfu_pkg::PH_HEAD;
        end else begin
          pcnt_d = pcnt_inc; phase_d = rtpfu_pkg::PH_PREFIX;
        end
      end
    endcase
  end

  assign cmd_valid_o = acc && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rtpfu_pkg::PH_PREFIX; pcnt_q <= '0; nal_q <= '0; frag_q <= '0;
      seq_q <= '0; time_q <= '0; ind_q <= '0; typ_q <= '0;
      spend_q <= 1'b0; frag_on_q <= 1'b0;
    end else if (acc) begin
      phase_q <= phase_d; pcnt_q <= pcnt_d; nal_q <= nal_d; frag_q <= frag_d;
      seq_q <= seq_d; time_q <= time_d; ind_q <= ind_d; typ_q <= typ_d;
      spend_q <= spend_d; frag_on_q <= frag_on_d;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rtpfu_queue.sv =====
// ----------------------------------------------------------------------------
// rtpfu_queue
// Two-entry command queue between parser and packet serializer.
// ----------------------------------------------------------------------------
`default_nettype none
module rtpfu_queue (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       wr_valid_i,
  output logic            wr_ready_o,
  input  wire rtpfu_pkg::cmd_t wr_cmd_i,
  output logic            rd_valid_o,
  input  wire logic       rd_ready_i,
  output rtpfu_pkg::cmd_t rd_cmd_o
);
  rtpfu_pkg::cmd_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_cmd_o   = mem_q[rptr_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= wr_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0; rptr_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wptr_q <= ~wptr_q;
      if (rd) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rtpfu_back.sv =====
// ----------------------------------------------------------------------------
// rtpfu_back
// Serializes one command into header, FU bytes and data byte.
// ----------------------------------------------------------------------------
`default_nettype none
module rtpfu_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_valid_i,
  output logic                  cmd_ready_o,
  input  wire rtpfu_pkg::cmd_t  cmd_i,
  input  wire rtpfu_pkg::hdr_cfg_t cfg_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output logic [7:0]            packet_byte_o,
  output logic                  packet_start_o,
  output logic                  packet_end_o
);
  logic [3:0] idx, idx_d, idx_q, first_idx;
  logic [7:0] b;
  logic       st, en, fire, done, busy_q;

  // byte index: 0..11 header, 12 FU indicator, 13 FU header, 14 data
  assign first_idx = cmd_i.hdr ? 4'd0 : 4'd14;
  // idx_q holds position within the current command; start position set on entry
  assign idx = busy_q ? idx_q : first_idx;

  always_comb begin
    st = 1'b0; en = 1'b0;
    case (idx)
      4'd0:  begin b = rtpfu_pkg::RtpVersion; st = 1'b1; end
      4'd1:  b = {cmd_i.marker, cfg_i.pay_kind};
      4'd2:  b = cmd_i.seq[15:8];
      4'd3:  b = cmd_i.seq[7:0];
      4'd4:  b = cmd_i.ts[31:24];
      4'd5:  b = cmd_i.ts[23:16];
      4'd6:  b = cmd_i.ts[15:8];
      4'd7:  b = cmd_i.ts[7:0];
      4'd8:  b = cfg_i.source_id[31:24];
      4'd9:  b = cfg_i.source_id[23:16];
      4'd10: b = cfg_i.source_id[15:8];
      4'd11: b = cfg_i.source_id[7:0];
      4'd12: b = cmd_i.fu_ind;
      4'd13: b = cmd_i.fu_hdr;
      default: begin b = cmd_i.data; en = cmd_i.last; end
    endcase
  end

  assign fire = cmd_valid_i && ready_i;
  assign done = (idx >= 4'd14);
  assign cmd_ready_o = fire && done;

  always_comb begin
    if (done) idx_d = 4'd15;
    else if (idx == 4'd11 && !cmd_i.fu) idx_d = 4'd14;
    else idx_d = idx + 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; idx_q <= 4'd0;
    end else if (fire) begin
      if (done) busy_q <= 1'b0;
      else begin busy_q <= 1'b1; idx_q <= idx_d; end
    end
  end

  assign valid_o        = cmd_valid_i;
  assign packet_byte_o  = b;
  assign packet_start_o = st;
  assign packet_end_o   = en;
endmodule
`default_nettype wire

// ===== rtl/rtpfu_outreg.sv =====
// ----------------------------------------------------------------------------
// rtpfu_outreg
// Skid output register for the packet byte stream.
// ----------------------------------------------------------------------------
`default_nettype none
module rtpfu_outreg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire logic [9:0] data_i,
  output logic            valid_o,
  input  wire logic       ready_i,
  output logic [9:0]      data_o
);
  logic       v_q, sv_q;
  logic [9:0] d_q, sd_q;
  assign ready_o = !sv_q;
  assign valid_o = v_q;
  assign data_o  = d_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0; sv_q <= 1'b0;
    end else begin
      if (!v_q || ready_i) begin
        v_q <= sv_q || valid_i;
        sv_q <= 1'b0;
      end else if (valid_i && ready_o) begin
        sv_q <= 1'b1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (!v_q || ready_i) d_q <= sv_q ? sd_q : data_i;
    if (valid_i && ready_o) sd_q <= data_i;
  end
endmodule
`default_nettype wire

// ===== rtl/h264_rtp_fua_packetizer.sv =====
// Each command is registered in the queue, its bytes in the output register.
// Throughput: one output byte per cycle while ready_i is high; a word that
//   opens a packet also sends the 12-byte header and, for FU-A, 2 FU bytes.
// Input is taken in the same cycle while the 2-entry command queue has room.
// Reset (rst_ni low, asynchronous) clears parse state, sequence counter and
//   registers to their defaults; no clearing pass.
// ----------------------------------------------------------------------------
// h264_rtp_fua_packetizer
// Byte-serial RTP packetizer: single NAL packets and FU-A fragments.
// ----------------------------------------------------------------------------
`default_nettype none
module h264_rtp_fua_packetizer #(
  parameter int unsigned NAL_LEN_BITS = rtpfu_pkg::NalLenBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        first_of_unit_i,
  input  wire logic        in_last_nal_i,
  input  wire logic [31:0] media_time_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic [7:0]       packet_byte_o,
  output logic             packet_start_o,
  output logic             packet_end_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  // Configuration registers, word-addressed at 4*index.
  logic [2:0]  len_q;
  logic [15:0] max_q, frag_q;
  logic [6:0]  kind_q;
  logic [31:0] ssrc_q;
  logic        wr_en;
  rtpfu_pkg::reg_idx_e ridx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign ridx   = rtpfu_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= rtpfu_pkg::LenBytesRst; max_q <= rtpfu_pkg::MaxSingleRst;
      frag_q <= rtpfu_pkg::FragPayRst; kind_q <= rtpfu_pkg::PayKindRst;
      ssrc_q <= rtpfu_pkg::SourceIdRst;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      case (ridx)
        rtpfu_pkg::REG_LEN_BYTES:  len_q  <= pwdata[2:0];
        rtpfu_pkg::REG_MAX_SINGLE: max_q  <= pwdata[15:0];
        rtpfu_pkg::REG_FRAG_PAY:   frag_q <= pwdata[15:0];
        rtpfu_pkg::REG_PAY_KIND:   kind_q <= pwdata[6:0];
        rtpfu_pkg::REG_SOURCE_ID:  ssrc_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      rtpfu_pkg::REG_LEN_BYTES:  prdata = {29'd0, len_q};
      rtpfu_pkg::REG_MAX_SINGLE: prdata = {16'd0, max_q};
      rtpfu_pkg::REG_FRAG_PAY:   prdata = {16'd0, frag_q};
      rtpfu_pkg::REG_PAY_KIND:   prdata = {25'd0, kind_q};
      rtpfu_pkg::REG_SOURCE_ID:  prdata = ssrc_q;
      default:                   prdata = 32'd0;
    endcase
  end

  // Front end: parse and decide; one command per word that emits bytes.
  rtpfu_pkg::cmd_t fcmd, qcmd;
  logic fvalid, fready, qvalid, qready;
  rtpfu_pkg::hdr_cfg_t hcfg;
  logic bvalid, bready;
  logic [7:0] bbyte;
  logic bst, ben;

  rtpfu_front #(.NAL_LEN_BITS(NAL_LEN_BITS)) u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o,
    .data_byte_i, .first_of_unit_i, .in_last_nal_i, .media_time_i,
    .len_bytes_i(len_q), .max_single_i(max_q), .frag_pay_i(frag_q),
    .cmd_valid_o(fvalid), .cmd_ready_i(fready), .cmd_o(fcmd)
  );

  rtpfu_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fvalid), .wr_ready_o(fready), .wr_cmd_i(fcmd),
    .rd_valid_o(qvalid), .rd_ready_i(qready), .rd_cmd_o(qcmd)
  );

  assign hcfg.pay_kind  = kind_q;
  assign hcfg.source_id = ssrc_q;

  // Back end: expands each command into header/FU/data bytes.
  rtpfu_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(qvalid), .cmd_ready_o(qready), .cmd_i(qcmd), .cfg_i(hcfg),
    .valid_o(bvalid), .ready_i(bready),
    .packet_byte_o(bbyte), .packet_start_o(bst), .packet_end_o(ben)
  );

  logic [9:0] odata;
  rtpfu_outreg u_out (
    .clk_i, .rst_ni,
    .valid_i(bvalid), .ready_o(bready), .data_i({bbyte, bst, ben}),
    .valid_o, .ready_i, .data_o(odata)
  );
  assign packet_byte_o  = odata[9:2];
  assign packet_start_o = odata[1];
  assign packet_end_o   = odata[0];
endmodule
`default_nettype wire

// ===== rtl/rtpfu_checker.sv =====
// ----------------------------------------------------------------------------
// rtpfu_checker
// Port-level checks on the packetizer output stream.
// ----------------------------------------------------------------------------
`default_nettype none
module rtpfu_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       valid_o,
  input wire logic       ready_i,
  input wire logic [7:0] packet_byte_o,
  input wire logic       packet_start_o,
  input wire logic       packet_end_o,
  input wire logic       pready
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(packet_byte_o))
    else $error("output word dropped under stall");
  a_start_ver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && packet_start_o |-> packet_byte_o == 8'h80)
    else $error("packet does not open with version byte");
  a_start_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && packet_start_o |-> !packet_end_o)
    else $error("header byte marked as end");
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
endmodule

bind h264_rtp_fua_packetizer rtpfu_checker u_chk (
  .clk_i, .rst_ni, .valid_o, .ready_i, .packet_byte_o,
  .packet_start_o, .packet_end_o, .pready
);
`default_nettype wire
